/* hw/rtl/cmjr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmjr_pkg
// Shared types and constants of the clamped multi-joint ramp.
// ----------------------------------------------------------------------------
package cmjr_pkg;

  localparam int unsigned NumJointsDef     = 12;
  localparam int unsigned StepCountBitsDef = 16;

  // angle formats: Q3.12 at the ports, Q3.28 inside
  localparam int unsigned AngleW  = 16;
  localparam int unsigned PosW    = 32;
  localparam int unsigned FracExt = PosW - AngleW;
  // magnitude of (target - position) in Q3.28 needs one bit more than a position
  localparam int unsigned DivMagW = PosW + 1;
  localparam int unsigned JointW  = 4;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned NumCfg  = 6;

  typedef enum logic [1:0] {
    OP_LOAD_POS  = 2'd0,
    OP_LOAD_TGT  = 2'd1,
    OP_START     = 2'd2,
    OP_TICK      = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    REG_WING_HIGH     = 3'd0,
    REG_WING_LOW      = 3'd1,
    REG_SHOULDER_HIGH = 3'd2,
    REG_SHOULDER_LOW  = 3'd3,
    REG_ELBOW_HIGH    = 3'd4,
    REG_ELBOW_LOW     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    JT_WING     = 2'd0,
    JT_SHOULDER = 2'd1,
    JT_ELBOW    = 2'd2
  } joint_type_e;

  typedef logic signed [AngleW-1:0] angle_t;

  localparam angle_t WingHighRst     = 16'sd2048;
  localparam angle_t WingLowRst      = -16'sd2048;
  localparam angle_t ShoulderHighRst = 16'sd12861;
  localparam angle_t ShoulderLowRst  = 16'sd0;
  localparam angle_t ElbowHighRst    = 16'sd7864;
  localparam angle_t ElbowLowRst     = 16'sd1065;

endpackage

/* hw/rtl/cmjr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmjr_div
// Bit-serial signed divider: one quotient bit per cycle, saturated to 32 bits.
// ----------------------------------------------------------------------------
module cmjr_div
  import cmjr_pkg::*;
#(
  parameter int unsigned STEP_COUNT_BITS = StepCountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       neg_i,
  input  logic [DivMagW-1:0]         mag_i,
  input  logic [STEP_COUNT_BITS-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic signed [PosW-1:0]     quot_o
);

  localparam int unsigned CntW = $clog2(DivMagW + 1);

  logic                       busy_q;
  logic                       done_q;
  logic [CntW-1:0]            cnt_q;
  logic [DivMagW-1:0]         quo_q;
  logic [STEP_COUNT_BITS-1:0] rem_q;
  logic [STEP_COUNT_BITS-1:0] dvs_q;
  logic                       neg_q;

  logic [STEP_COUNT_BITS:0]   rem_sh;
  logic [STEP_COUNT_BITS:0]   rem_sub;
  logic                       ge;
  logic [DivMagW-1:0]         quo_neg;

  assign rem_sh  = {rem_q, quo_q[DivMagW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivMagW);
        quo_q  <= mag_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        neg_q  <= neg_i;
      end else if (busy_q) begin
        rem_q <= ge ? rem_sub[STEP_COUNT_BITS-1:0] : rem_sh[STEP_COUNT_BITS-1:0];
        quo_q <= {quo_q[DivMagW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // saturate the signed quotient to 32 bits
  assign quo_neg = -quo_q;

  always_comb begin
    if (neg_q) begin
      if (quo_q > {1'b0, 1'b1, {(PosW-1){1'b0}}}) begin
        quot_o = {1'b1, {(PosW-1){1'b0}}};
      end else begin
        quot_o = quo_neg[PosW-1:0];
      end
    end else begin
      if (quo_q > {2'b00, {(PosW-1){1'b1}}}) begin
        quot_o = {1'b0, {(PosW-1){1'b1}}};
      end else begin
        quot_o = quo_q[PosW-1:0];
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

/* hw/rtl/clamped_multi_joint_ramp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_multi_joint_ramp
// Linear setpoint ramp over NUM_JOINTS joints with per-type clamping.
// ----------------------------------------------------------------------------
// A start with a non-zero step count runs NUM_JOINTS divisions on one shared
// bit-serial divider; each division loads the divider, shifts out 33 quotient
// bits and writes the increment back, and in_ready_o stays low meanwhile. A
// tick steps one joint per cycle through a single adder and clamp and streams
// one setpoint item per cycle while the output side does not stall. Ticks
// while no move runs emit the current setpoints with move_done_o low.
// ----------------------------------------------------------------------------
module clamped_multi_joint_ramp
  import cmjr_pkg::*;
#(
  parameter int unsigned NUM_JOINTS      = NumJointsDef,
  parameter int unsigned STEP_COUNT_BITS = StepCountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [AddrW-1:0]           paddr,
  input  logic [DataW-1:0]           pwdata,
  output logic [DataW-1:0]           prdata,
  output logic                       pready,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [JointW-1:0]          joint_i,
  input  logic signed [AngleW-1:0]   angle_i,
  input  logic [STEP_COUNT_BITS-1:0] step_count_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [JointW-1:0]          setpoint_joint_o,
  output logic signed [AngleW-1:0]   setpoint_o,
  output logic                       last_o,
  output logic                       move_done_o
);

  localparam int unsigned JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_LOAD,
    S_DIV_WAIT,
    S_TICK
  } state_e;

  state_e                      state_q;
  logic [JW-1:0]               k_q;
  joint_type_e                 ty_q;
  logic [STEP_COUNT_BITS-1:0]  ticks_q;
  logic [STEP_COUNT_BITS-1:0]  dvs_q;
  logic                        moving_q;
  logic                        final_q;

  angle_t                      cfg_q [NumCfg];
  logic signed [PosW-1:0]      pos_q [NUM_JOINTS];
  angle_t                      tgt_q [NUM_JOINTS];
  logic signed [PosW-1:0]      inc_q [NUM_JOINTS];

  logic                        out_valid_q;
  logic [JointW-1:0]           sp_joint_q;
  angle_t                      sp_q;
  logic                        last_q;
  logic                        done_q;

  logic                        cfg_we;
  logic                        in_acc;
  logic                        ld_ok;
  logic [JW-1:0]               ld_idx;
  logic                        k_last;
  logic                        out_free;

  logic signed [DivMagW:0]     diff;
  logic signed [DivMagW:0]     diff_neg;
  logic                        div_start;
  logic                        div_busy;
  logic                        div_done;
  logic signed [PosW-1:0]      div_quot;

  angle_t                      lim_hi;
  angle_t                      lim_lo;
  logic signed [PosW:0]        hi_ext;
  logic signed [PosW:0]        lo_ext;
  logic signed [PosW:0]        sum;
  logic signed [PosW-1:0]      pos_d;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (32'(paddr[4:2]) < NumCfg) begin
      prdata = DataW'(cfg_q[paddr[4:2]]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_WING_HIGH]     <= WingHighRst;
      cfg_q[REG_WING_LOW]      <= WingLowRst;
      cfg_q[REG_SHOULDER_HIGH] <= ShoulderHighRst;
      cfg_q[REG_SHOULDER_LOW]  <= ShoulderLowRst;
      cfg_q[REG_ELBOW_HIGH]    <= ElbowHighRst;
      cfg_q[REG_ELBOW_LOW]     <= ElbowLowRst;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_WING_HIGH:     cfg_q[REG_WING_HIGH]     <= pwdata[AngleW-1:0];
        REG_WING_LOW:      cfg_q[REG_WING_LOW]      <= pwdata[AngleW-1:0];
        REG_SHOULDER_HIGH: cfg_q[REG_SHOULDER_HIGH] <= pwdata[AngleW-1:0];
        REG_SHOULDER_LOW:  cfg_q[REG_SHOULDER_LOW]  <= pwdata[AngleW-1:0];
        REG_ELBOW_HIGH:    cfg_q[REG_ELBOW_HIGH]    <= pwdata[AngleW-1:0];
        REG_ELBOW_LOW:     cfg_q[REG_ELBOW_LOW]     <= pwdata[AngleW-1:0];
        default: ;
      endcase
    end
  end

  // handshake and indexing
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign ld_ok      = 32'(joint_i) < NUM_JOINTS;
  assign ld_idx     = JW'(joint_i);
  assign k_last     = (k_q == JW'(NUM_JOINTS - 1));
  assign out_free   = !out_valid_q || out_ready_i;

  // increment = (target - position) / steps
  assign diff      = {{2{tgt_q[k_q][AngleW-1]}}, tgt_q[k_q], {FracExt{1'b0}}}
                   - {{2{pos_q[k_q][PosW-1]}}, pos_q[k_q]};
  assign diff_neg  = -diff;
  assign div_start = (state_q == S_DIV_LOAD);

  cmjr_div #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .neg_i     (diff[DivMagW]),
    .mag_i     (diff[DivMagW] ? diff_neg[DivMagW-1:0] : diff[DivMagW-1:0]),
    .divisor_i (dvs_q),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // tick: add and clamp, high limit first; hold the position while no move runs
  always_comb begin
    unique case (ty_q)
      JT_WING: begin
        lim_hi = cfg_q[REG_WING_HIGH];
        lim_lo = cfg_q[REG_WING_LOW];
      end
      JT_SHOULDER: begin
        lim_hi = cfg_q[REG_SHOULDER_HIGH];
        lim_lo = cfg_q[REG_SHOULDER_LOW];
      end
      default: begin
        lim_hi = cfg_q[REG_ELBOW_HIGH];
        lim_lo = cfg_q[REG_ELBOW_LOW];
      end
    endcase
    hi_ext = {lim_hi[AngleW-1], lim_hi, {FracExt{1'b0}}};
    lo_ext = {lim_lo[AngleW-1], lim_lo, {FracExt{1'b0}}};
    sum    = {pos_q[k_q][PosW-1], pos_q[k_q]} + {inc_q[k_q][PosW-1], inc_q[k_q]};
    priority if (!moving_q) begin
      pos_d = pos_q[k_q];
    end else if (sum > hi_ext) begin
      pos_d = hi_ext[PosW-1:0];
    end else if (lo_ext > sum) begin
      pos_d = lo_ext[PosW-1:0];
    end else begin
      pos_d = sum[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      ty_q        <= JT_WING;
      ticks_q     <= '0;
      dvs_q       <= '0;
      moving_q    <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
      sp_joint_q  <= '0;
      sp_q        <= '0;
      last_q      <= 1'b0;
      done_q      <= 1'b0;
      for (int i = 0; i < NUM_JOINTS; i++) begin
        pos_q[i] <= '0;
        tgt_q[i] <= '0;
        inc_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_TICK)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (opcode_e'(opcode_i))
              OP_LOAD_POS: begin
                if (ld_ok) begin
                  pos_q[ld_idx] <= {angle_i, {FracExt{1'b0}}};
                end
              end
              OP_LOAD_TGT: begin
                if (ld_ok) begin
                  tgt_q[ld_idx] <= angle_i;
                end
              end
              OP_START: begin
                if (step_count_i != '0) begin
                  ticks_q <= step_count_i;
                  dvs_q   <= step_count_i;
                  k_q     <= '0;
                  state_q <= S_DIV_LOAD;
                end
              end
              OP_TICK: begin
                k_q      <= '0;
                ty_q     <= JT_WING;
                moving_q <= (ticks_q != '0);
                final_q  <= (ticks_q == STEP_COUNT_BITS'(1));
                if (ticks_q != '0) begin
                  ticks_q <= ticks_q - 1'b1;
                end
                state_q  <= S_TICK;
              end
              default: ;
            endcase
          end
        end
        S_DIV_LOAD: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            inc_q[k_q] <= div_quot;
            if (k_last) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_DIV_LOAD;
            end
          end
        end
        S_TICK: begin
          if (out_free) begin
            pos_q[k_q]  <= pos_d;
            out_valid_q <= 1'b1;
            sp_joint_q  <= JointW'(k_q);
            sp_q        <= pos_d[PosW-1:FracExt];
            last_q      <= k_last;
            done_q      <= final_q;
            ty_q        <= (ty_q == JT_ELBOW) ? JT_WING : joint_type_e'(ty_q + 2'd1);
            if (k_last) begin
              state_q <= S_IDLE;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign setpoint_joint_o = sp_joint_q;
  assign setpoint_o       = sp_q;
  assign last_o           = last_q;
  assign move_done_o      = done_q;

  // divider is only started when free
  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // divider results only arrive while the sequencer waits for them
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV_WAIT))
    else $error("divider result outside wait state");

  // an accepted tick always starts the setpoint stream
  a_tick_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (opcode_i == OP_TICK)) |=> (state_q == S_TICK))
    else $error("tick item did not start stream");

endmodule
